@@ sv/asp_pkg.sv @@
package asp_pkg;

    // Packet geometry
    localparam int PKT_SAMPLES = 64;
    localparam int SAMPLE_W    = 16;
    localparam int HDR_BYTES   = 10;
    localparam int PKT_BYTES   = HDR_BYTES + 2 * PKT_SAMPLES;
    localparam int PKT_WORDS   = (PKT_BYTES + 3) / 4;
    localparam int LAST_BYTES  = PKT_BYTES - 4 * (PKT_WORDS - 1);
    localparam int SAMPLE_RATE = 24000;

    // Sample store: even and odd samples live in separate banks
    localparam int BANK_DEPTH = (PKT_SAMPLES + 1) / 2;
    localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
    localparam int FILL_W     = $clog2(PKT_SAMPLES + 1);
    localparam int WIDX_W     = $clog2(PKT_WORDS);

    // Port widths
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 72;
    localparam int BCNT_W      = 3;

    // Header sync bytes
    localparam logic [7:0] SYNC0 = 8'hA5;
    localparam logic [7:0] SYNC1 = 8'h5A;
    localparam logic [7:0] SYNC2 = 8'h01;
    localparam logic [7:0] SYNC3 = 8'h01;

    // Mask for the bytes that are valid in the final word of a packet
    localparam logic [31:0] LAST_MASK = 32'hFFFF_FFFF >> (8 * (4 - LAST_BYTES));

    // Input opcodes
    localparam logic [1:0] OP_SLOT = 2'd0;
    localparam logic [1:0] OP_CTRL = 2'd1;
    localparam logic [1:0] OP_XERR = 2'd2;

    // Partner control bytes
    localparam logic [7:0] CTRL_READY = 8'hF0;
    localparam logic [7:0] CTRL_STOP  = 8'hF1;

    // Read request from the emitter to both sample banks
    typedef struct packed {
        logic               en;
        logic [BANK_AW-1:0] even_addr;
        logic [BANK_AW-1:0] odd_addr;
    } t_rd_req;

    // Packet start command from the ingest control to the emitter
    typedef struct packed {
        logic        start;
        logic [15:0] seq;
        logic [31:0] total;
    } t_emit_ctl;

endpackage

@@ sv/asp_ram.sv @@
module asp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Single write port and a registered read port that holds its data between reads.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/asp_emit.sv @@
module asp_emit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  asp_pkg::t_emit_ctl                  i_ctl,
    output asp_pkg::t_rd_req                    o_rd,
    input  logic [asp_pkg::SAMPLE_W-1:0]        i_even_data,
    input  logic [asp_pkg::SAMPLE_W-1:0]        i_odd_data,
    output logic                                o_done,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // Fields from bit 0: packet_bytes[31:0], byte_count[34:32], packets_sent[66:35], zero pad.
    output logic [asp_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    output logic                                m_axis_tlast
);

    import asp_pkg::*;

    logic              r_issuing;
    logic [WIDX_W-1:0] r_issue_k;
    logic              r_rd_vld;
    logic [WIDX_W-1:0] r_rd_k;
    logic              r_m_valid;
    logic [OUT_TDATA_W-1:0] r_m_data;
    logic              r_m_last;

    logic              load;
    logic              issue;
    logic              rd_last;
    logic [WIDX_W-1:0] odd_idx;
    logic [WIDX_W-1:0] even_idx;
    logic [31:0]       word;
    logic [BCNT_W-1:0] bcnt;

    // The output register frees up when empty or when its transaction completes.
    assign load    = r_rd_vld && (!r_m_valid || m_axis_tready);
    assign issue   = r_issuing && (!r_rd_vld || load);
    assign rd_last = (r_rd_k == WIDX_W'(PKT_WORDS - 1));

    // Word k carries odd sample 2k-5 in its low half and even sample 2k-4 in its high half.
    assign odd_idx  = r_issue_k - WIDX_W'(3);
    assign even_idx = r_issue_k - WIDX_W'(2);

    assign o_rd.en        = issue;
    assign o_rd.odd_addr  = odd_idx[BANK_AW-1:0];
    assign o_rd.even_addr = even_idx[BANK_AW-1:0];

    // Assemble the packet word that the banks have just returned.
    always_comb begin
        priority if (r_rd_k == WIDX_W'(0)) begin
            word = {SYNC3, SYNC2, SYNC1, SYNC0};
        end else if (r_rd_k == WIDX_W'(1)) begin
            word = {16'(PKT_SAMPLES), i_ctl.seq};
        end else if (r_rd_k == WIDX_W'(2)) begin
            word = {i_even_data, 16'(SAMPLE_RATE)};
        end else begin
            word = {i_even_data, i_odd_data};
        end
        if (rd_last) begin
            word = word & LAST_MASK;
            bcnt = BCNT_W'(LAST_BYTES);
        end else begin
            bcnt = BCNT_W'(4);
        end
    end

    // Read sequencing and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issuing <= 1'b0;
            r_issue_k <= '0;
            r_rd_vld  <= 1'b0;
            r_rd_k    <= '0;
            r_m_valid <= 1'b0;
            r_m_last  <= 1'b0;
        end else begin
            if (i_ctl.start) begin
                r_issuing <= 1'b1;
                r_issue_k <= '0;
            end else if (issue) begin
                r_issue_k <= r_issue_k + WIDX_W'(1);
                if (r_issue_k == WIDX_W'(PKT_WORDS - 1)) begin
                    r_issuing <= 1'b0;
                end
            end
            if (issue) begin
                r_rd_vld <= 1'b1;
                r_rd_k   <= r_issue_k;
            end else if (load) begin
                r_rd_vld <= 1'b0;
            end
            if (load) begin
                r_m_valid <= 1'b1;
                r_m_last  <= rd_last;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // Payload of the output register.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_m_data <= {5'b0, i_ctl.total, bcnt, word};
        end
    end

    assign o_done        = load && rd_last;
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tlast  = r_m_last;

endmodule

@@ sv/audio_slot_packetizer.sv @@
// Packs one kept slot in every four input slot words into framed packets of PKT_SAMPLES samples.
// After the completing sample is taken, the first packet word passes the issue flag, the bank read
// register and the output register. Throughput: one input item per cycle between packets; a packet
// (PKT_WORDS, 35 words) streams from the sample banks at one word per cycle unless stalled, and
// input waits until its last word is loaded. Reset is synchronous and active low; it clears control
// state and counters, while the sample banks keep their contents and are only read after being written.
module audio_slot_packetizer (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic                                i_cfg_wdata,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // Fields from bit 0: slot_word[15:0], control_byte[23:16].
    input  logic [asp_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // Fields from bit 0: opcode[1:0].
    input  logic [1:0]                          s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // Fields from bit 0: packet_bytes[31:0], byte_count[34:32], packets_sent[66:35], zero pad.
    output logic [asp_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    output logic                                m_axis_tlast
);

    import asp_pkg::*;

    typedef enum logic {
        S_ACCEPT,
        S_EMIT
    } t_state;

    t_state            r_state, n_state;
    logic              r_offset;
    logic              r_partner, n_partner;
    logic              r_streaming, n_streaming;
    logic [1:0]        r_phase, n_phase;
    logic [FILL_W-1:0] r_fill, n_fill;
    logic [15:0]       r_seq, n_seq;
    logic [31:0]       r_total, n_total;

    logic                  accept;
    logic [SAMPLE_W-1:0]   slot_word;
    logic [7:0]            ctl_byte;
    logic                  wr_en;
    logic                  start;
    logic [FILL_W-2:0]     wr_half;
    logic [FILL_W-1:0]     fill_inc;
    logic                  done;
    t_rd_req               rd;
    t_emit_ctl             ctl;
    logic [SAMPLE_W-1:0]   even_data;
    logic [SAMPLE_W-1:0]   odd_data;

    assign s_axis_tready = (r_state == S_ACCEPT);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign slot_word     = s_axis_tdata[15:0];
    assign ctl_byte      = s_axis_tdata[23:16];
    assign fill_inc      = r_fill + FILL_W'(1);
    assign wr_half       = r_fill[FILL_W-1:1];

    // Next-state logic for the session, slot selection and fill counters.
    always_comb begin
        n_state     = r_state;
        n_partner   = r_partner;
        n_streaming = r_streaming;
        n_phase     = r_phase;
        n_fill      = r_fill;
        n_seq       = r_seq;
        n_total     = r_total;
        wr_en       = 1'b0;
        start       = 1'b0;
        unique case (r_state)
            S_ACCEPT: begin
                if (accept) begin
                    unique case (s_axis_tuser)
                        OP_SLOT: begin
                            if (r_streaming) begin
                                n_phase = r_phase + 2'd1;
                                if (r_phase == {1'b0, r_offset}) begin
                                    wr_en = 1'b1;
                                    if (fill_inc == FILL_W'(PKT_SAMPLES)) begin
                                        n_fill  = '0;
                                        n_total = r_total + 32'd1;
                                        start   = 1'b1;
                                        n_state = S_EMIT;
                                    end else begin
                                        n_fill = fill_inc;
                                    end
                                end
                            end
                        end
                        OP_CTRL: begin
                            if (ctl_byte == CTRL_READY) begin
                                n_partner = 1'b1;
                                if (!r_streaming) begin
                                    n_streaming = 1'b1;
                                    n_fill      = '0;
                                    n_phase     = '0;
                                    n_seq       = '0;
                                    n_total     = '0;
                                end
                            end else if (ctl_byte == CTRL_STOP) begin
                                n_partner   = 1'b0;
                                n_streaming = 1'b0;
                                n_fill      = '0;
                            end
                        end
                        OP_XERR: begin
                            // A transfer error restarts a running session from scratch.
                            if (r_streaming) begin
                                n_fill      = '0;
                                n_streaming = r_partner;
                                if (r_partner) begin
                                    n_phase = '0;
                                    n_seq   = '0;
                                    n_total = '0;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_EMIT: begin
                if (done) begin
                    n_seq   = r_seq + 16'd1;
                    n_state = S_ACCEPT;
                end
            end
            default: begin
                n_state = S_ACCEPT;
            end
        endcase
    end

    // State and control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_ACCEPT;
            r_offset    <= 1'b0;
            r_partner   <= 1'b0;
            r_streaming <= 1'b0;
            r_phase     <= '0;
            r_fill      <= '0;
            r_seq       <= '0;
            r_total     <= '0;
        end else begin
            r_state     <= n_state;
            r_partner   <= n_partner;
            r_streaming <= n_streaming;
            r_phase     <= n_phase;
            r_fill      <= n_fill;
            r_seq       <= n_seq;
            r_total     <= n_total;
            if (i_cfg_we) begin
                r_offset <= i_cfg_wdata;
            end
        end
    end

    // Sample banks; a packet is only read after its last sample has been written,
    // so reads and writes never touch the same entry in one cycle.
    asp_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (BANK_DEPTH),
        .AW    (BANK_AW)
    ) u_even_bank (
        .i_clk   (i_clk),
        .i_we    (wr_en && !r_fill[0]),
        .i_waddr (wr_half[BANK_AW-1:0]),
        .i_wdata (slot_word),
        .i_re    (rd.en),
        .i_raddr (rd.even_addr),
        .o_rdata (even_data)
    );

    asp_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (BANK_DEPTH),
        .AW    (BANK_AW)
    ) u_odd_bank (
        .i_clk   (i_clk),
        .i_we    (wr_en && r_fill[0]),
        .i_waddr (wr_half[BANK_AW-1:0]),
        .i_wdata (slot_word),
        .i_re    (rd.en),
        .i_raddr (rd.odd_addr),
        .o_rdata (odd_data)
    );

    // Packet emitter.
    assign ctl.start = start;
    assign ctl.seq   = r_seq;
    assign ctl.total = r_total;

    asp_emit u_emit (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (ctl),
        .o_rd          (rd),
        .i_even_data   (even_data),
        .i_odd_data    (odd_data),
        .o_done        (done),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

@@ sv/asp_checker.sv @@
module asp_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [asp_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                            m_axis_tlast
);

    import asp_pkg::*;

    // The final word of a packet carries exactly the leftover bytes.
    a_last_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[34:32] == BCNT_W'(LAST_BYTES))
        else $error("final packet word has a wrong byte count");

    // Every other word of a packet is full.
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[34:32] == BCNT_W'(4))
        else $error("inner packet word is not full");

    // While a packet is still being sent, no new input is taken.
    a_no_input_mid_packet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
        else $error("input taken in the middle of a packet");

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled result changed");

endmodule

bind audio_slot_packetizer asp_checker u_asp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

@@ verif/testbench.sv @@
module testbench;

    import asp_pkg::*;

    localparam int CYCLE_LIMIT   = 2000000;
    localparam int SETTLE_CYCLES = 8;
    localparam int ITEM_TARGET   = 420;
    localparam int RANDOM_END    = 300;
    localparam int FINAL_MIN     = 30;
    localparam int MIN_PACKETS   = 1;
    localparam int MAX_BATCHES   = 6;

    // Opcode that the block has no use for.
    localparam logic [1:0]  OP_UNUSED  = 2'd3;
    localparam logic [15:0] COUNT_LE   = 16'(PKT_SAMPLES);
    localparam logic [15:0] RATE_LE    = 16'(SAMPLE_RATE);

    // One input transaction: opcode in tuser, control byte and slot word in tdata.
    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  ctl;
        logic [15:0] word;
    } t_slot_item;

    // One packet word as it should leave the block.
    typedef struct packed {
        logic [31:0] bytes;
        logic [2:0]  nbytes;
        logic        last;
        logic [31:0] sent;
    } t_pkt_word;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   i_cfg_we      = 1'b0;
    logic                   i_cfg_wdata   = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic [1:0]             s_axis_tuser  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tlast;

    audio_slot_packetizer u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Clock with a period of 8 time units.
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    t_slot_item pending_items [$];
    t_pkt_word  expected_words [$];
    int         items_queued   = 0;
    int         items_accepted = 0;
    int         err_count      = 0;
    int         cycle_count    = 0;
    bit         calm           = 1'b0;

    // Shadow copy of the packetizer state.
    logic        keep_offset = 1'b0;
    logic        sess_ready  = 1'b0;
    logic        sess_active = 1'b0;
    logic [1:0]  phase_ctr   = 2'd0;
    int          fill_ctr    = 0;
    logic [15:0] sample_mem [PKT_SAMPLES];
    logic [15:0] seq_ctr     = 16'd0;
    logic [31:0] pkt_ctr     = 32'd0;
    int          pkts_emitted = 0;

    task automatic report_mismatch(input string msg);
        err_count++;
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
    endtask

    task automatic open_session();
        sess_active = 1'b1;
        fill_ctr    = 0;
        phase_ctr   = 2'd0;
        seq_ctr     = 16'd0;
        pkt_ctr     = 32'd0;
    endtask

    // Applies one accepted transaction to the shadow state and queues any packet words.
    task automatic packetize_item(input t_slot_item it);
        logic [7:0] pkt [PKT_BYTES];
        t_pkt_word  w;
        logic       keep;
        int         pos;
        int         k;
        int         b;
        case (it.op)
            OP_SLOT: begin
                if (sess_active) begin
                    keep      = (phase_ctr == {1'b0, keep_offset});
                    phase_ctr = phase_ctr + 2'd1;
                    if (keep) begin
                        sample_mem[fill_ctr] = it.word;
                        fill_ctr++;
                        if (fill_ctr >= PKT_SAMPLES) begin
                            pkt_ctr = pkt_ctr + 32'd1;
                            pkts_emitted++;
                            pkt[0] = SYNC0;
                            pkt[1] = SYNC1;
                            pkt[2] = SYNC2;
                            pkt[3] = SYNC3;
                            pkt[4] = seq_ctr[7:0];
                            pkt[5] = seq_ctr[15:8];
                            pkt[6] = COUNT_LE[7:0];
                            pkt[7] = COUNT_LE[15:8];
                            pkt[8] = RATE_LE[7:0];
                            pkt[9] = RATE_LE[15:8];
                            for (k = 0; k < PKT_SAMPLES; k++) begin
                                pkt[HDR_BYTES + 2 * k]     = sample_mem[k][7:0];
                                pkt[HDR_BYTES + 2 * k + 1] = sample_mem[k][15:8];
                            end
                            // Cut the byte stream into words of up to four bytes.
                            pos = 0;
                            while (pos < PKT_BYTES) begin
                                w      = '0;
                                w.sent = pkt_ctr;
                                for (b = 0; b < 4 && pos < PKT_BYTES; b++) begin
                                    w.bytes[8 * b +: 8] = pkt[pos];
                                    w.nbytes = w.nbytes + 3'd1;
                                    pos++;
                                end
                                w.last = (pos >= PKT_BYTES);
                                expected_words.push_back(w);
                            end
                            seq_ctr  = seq_ctr + 16'd1;
                            fill_ctr = 0;
                        end
                    end
                end
            end
            OP_CTRL: begin
                if (it.ctl == CTRL_READY) begin
                    sess_ready = 1'b1;
                    if (!sess_active)
                        open_session();
                end else if (it.ctl == CTRL_STOP) begin
                    sess_ready  = 1'b0;
                    sess_active = 1'b0;
                    fill_ctr    = 0;
                end
            end
            OP_XERR: begin
                // A transfer error drops the partial packet and restarts the session.
                if (sess_active) begin
                    fill_ctr    = 0;
                    sess_active = 1'b0;
                    if (sess_ready)
                        open_session();
                end
            end
            default: begin
            end
        endcase
    endtask

    // Input driver: holds each transaction until accepted, with random idle bursts.
    t_slot_item cur_item;
    int         send_gap = 0;
    logic       send_vld;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            send_vld = s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready) begin
                packetize_item(cur_item);
                items_accepted++;
                send_vld = 1'b0;
            end
            if (!send_vld) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (!calm && pending_items.size() != 0 &&
                             $urandom_range(0, 7) == 0) begin
                    send_gap = $urandom_range(0, 14);
                end else if (pending_items.size() != 0) begin
                    cur_item     = pending_items.pop_front();
                    send_vld     = 1'b1;
                    s_axis_tdata <= {cur_item.ctl, cur_item.word};
                    s_axis_tuser <= cur_item.op;
                end
            end
            s_axis_tvalid <= send_vld;
        end
    end

    // Output monitor: checks each packet word and stalls the output at random.
    t_pkt_word want;
    int        recv_gap = 0;
    logic      recv_rdy;

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_words.size() == 0) begin
                report_mismatch($sformatf("packet word %h with none expected", m_axis_tdata));
            end else begin
                want = expected_words.pop_front();
                if (m_axis_tdata[31:0] !== want.bytes)
                    report_mismatch($sformatf("packet_bytes %h, expected %h",
                                              m_axis_tdata[31:0], want.bytes));
                if (m_axis_tdata[34:32] !== want.nbytes)
                    report_mismatch($sformatf("byte_count %0d, expected %0d",
                                              m_axis_tdata[34:32], want.nbytes));
                if (m_axis_tlast !== want.last)
                    report_mismatch($sformatf("packet_end %b, expected %b",
                                              m_axis_tlast, want.last));
                if (m_axis_tdata[66:35] !== want.sent)
                    report_mismatch($sformatf("packets_sent %0d, expected %0d",
                                              m_axis_tdata[66:35], want.sent));
            end
        end
        if (recv_gap > 0) begin
            recv_gap--;
            recv_rdy = 1'b0;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
            recv_gap = $urandom_range(0, 14);
            recv_rdy = 1'b0;
        end else begin
            recv_rdy = 1'b1;
        end
        m_axis_tready <= recv_rdy;
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("** audio_slot_packetizer: FAILED **");
            $finish;
        end
    end

    function automatic t_slot_item make_item(logic [1:0] op, logic [7:0] ctl,
                                             logic [15:0] word);
        make_item = {op, ctl, word};
    endfunction

    task automatic push_item(input t_slot_item it);
        pending_items.push_back(it);
        items_queued++;
    endtask

    task automatic push_slot(input logic [15:0] word);
        push_item(make_item(OP_SLOT, 8'($urandom), word));
    endtask

    // Waits until every transaction is taken and every packet word has arrived.
    task automatic wait_drained();
        while (items_accepted != items_queued || expected_words.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_offset(input logic value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        keep_offset = value;
    endtask

    // A session start followed by a long run of slot words with a little harmless noise
    // mixed in, so that the run normally completes a packet.
    task automatic push_session_run(input int n_slots);
        int i;
        push_item(make_item(OP_CTRL, CTRL_READY, 16'($urandom)));
        for (i = 0; i < n_slots; i++) begin
            if ($urandom_range(0, 59) == 0)
                push_item(make_item(($urandom_range(0, 1) == 0) ? OP_CTRL : OP_UNUSED,
                                    8'($urandom), 16'($urandom)));
            else
                push_slot(16'($urandom));
        end
        if ($urandom_range(0, 1) == 0)
            push_item(make_item(OP_CTRL, CTRL_STOP, 16'($urandom)));
    endtask

    initial begin
        int         batch;
        int         i;
        int         n;
        logic [1:0] op;
        logic [7:0] ctl;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        set_offset(1'b0);

        // Directed part: idle behavior, ignored codes, session start, error and stop.
        push_slot(16'hFFFF);
        push_item(make_item(OP_XERR, 8'hFF, 16'hFFFF));
        push_item(make_item(OP_CTRL, CTRL_STOP, 16'h0000));
        push_item(make_item(OP_CTRL, 8'h00, 16'h0000));
        push_item(make_item(OP_UNUSED, 8'hFF, 16'hFFFF));
        push_item(make_item(OP_CTRL, CTRL_READY, 16'h0000));
        push_item(make_item(OP_CTRL, CTRL_READY, 16'hFFFF));
        push_slot(16'h0000);
        push_slot(16'hFFFF);
        push_slot(16'h8000);
        push_slot(16'h0001);
        push_item(make_item(OP_XERR, 8'h00, 16'h0000));
        push_slot(16'h7FFF);
        push_slot(16'h00FF);
        push_slot(16'hFF00);
        push_item(make_item(OP_CTRL, 8'hFF, 16'h1234));
        push_item(make_item(OP_CTRL, CTRL_STOP, 16'hFFFF));
        push_slot(16'hAAAA);
        push_item(make_item(OP_XERR, 8'h55, 16'h5555));
        push_item(make_item(OP_CTRL, CTRL_READY, 16'h0000));
        push_slot(16'h5555);
        push_slot(16'hAAAA);
        push_slot(16'hFFFF);
        wait_drained();

        // Random part: mostly a long session, sometimes a burst of mixed noise.
        for (batch = 0; batch < MAX_BATCHES &&
             !(items_queued >= RANDOM_END && pkts_emitted >= MIN_PACKETS); batch++) begin
            set_offset(batch[0] ^ 1'b1);
            if ($urandom_range(0, 3) == 0) begin
                n = $urandom_range(10, 40);
                for (i = 0; i < n; i++) begin
                    op = 2'($urandom_range(0, 3));
                    case ($urandom_range(0, 2))
                        0:       ctl = CTRL_READY;
                        1:       ctl = CTRL_STOP;
                        default: ctl = 8'($urandom);
                    endcase
                    push_item(make_item(op, ctl, 16'($urandom)));
                end
            end else begin
                push_session_run($urandom_range(270, 300));
            end
            wait_drained();
        end

        // Final stretch without idling on either side.
        set_offset(1'($urandom_range(0, 1)));
        calm = 1'b1;
        n = ITEM_TARGET - items_queued;
        if (n < FINAL_MIN)
            n = FINAL_MIN;
        push_session_run(n);
        wait_drained();

        if (err_count == 0)
            $display("** audio_slot_packetizer: PASSED **");
        else
            $display("** audio_slot_packetizer: FAILED **");
        $finish;
    end

endmodule

@@ filelist.f @@
sv/asp_pkg.sv
sv/asp_ram.sv
sv/asp_emit.sv
sv/audio_slot_packetizer.sv
sv/asp_checker.sv
verif/testbench.sv
